>>> sv/qapm_pkg.sv
`timescale 1ns / 1ps

package qapm_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int GAIN_BITS     = 20;

  localparam int IN_W    = 24;
  localparam int DIFF_W  = IN_W + 1;
  localparam int VAL_W   = 28;
  localparam int GAIN_W  = 27;
  localparam int PROD_W  = VAL_W + GAIN_W;
  localparam int RND_W   = 32;
  localparam int INT_W   = 32;
  localparam int ACC_W   = 32;
  localparam int MIX_W   = ACC_W + 2;
  localparam int PULSE_W = 11;

  localparam logic [PULSE_W-1:0] PULSE_MIN = 11'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX = 11'd2000;

  localparam logic signed [INT_W-1:0] LIM_100 = INT_W'(100 << FRACTION_BITS);
  localparam logic signed [INT_W-1:0] LIM_150 = INT_W'(150 << FRACTION_BITS);

  // one multiply per operation, in this order
  typedef enum logic [3:0] {
    OP_ANG_P_X,
    OP_ANG_I_X,
    OP_RATE_I_X,
    OP_RATE_P_X,
    OP_RATE_D_X,
    OP_ANG_P_Y,
    OP_ANG_I_Y,
    OP_RATE_I_Y,
    OP_RATE_P_Y,
    OP_RATE_D_Y,
    OP_YAW_I,
    OP_YAW_P,
    OP_YAW_D
  } op_t;

  // gains with GAIN_BITS fraction bits, tick time folded in
  function automatic logic [GAIN_W-1:0] gain_of(op_t op);
    logic [GAIN_W-1:0] g;
    case (op)
      OP_ANG_P_X:  g = GAIN_W'(3774874);
      OP_ANG_I_X:  g = GAIN_W'(4089);
      OP_RATE_I_X: g = GAIN_W'(31);
      OP_RATE_P_X: g = GAIN_W'(2516582);
      OP_RATE_D_X: g = GAIN_W'(699051);
      OP_ANG_P_Y:  g = GAIN_W'(3670016);
      OP_ANG_I_Y:  g = GAIN_W'(315);
      OP_RATE_I_Y: g = GAIN_W'(315);
      OP_RATE_P_Y: g = GAIN_W'(2202010);
      OP_RATE_D_Y: g = GAIN_W'(1572864);
      OP_YAW_I:    g = GAIN_W'(2202);
      OP_YAW_P:    g = GAIN_W'(2621440);
      OP_YAW_D:    g = GAIN_W'(34952533);
      default:     g = '0;
    endcase
    return g;
  endfunction

  function automatic logic signed [INT_W-1:0] clamp_int(logic signed [INT_W:0] v,
                                                         logic signed [INT_W-1:0] lim);
    logic signed [INT_W:0] hi;
    logic signed [INT_W:0] lo;
    hi = (INT_W+1)'(lim);
    lo = -hi;
    if (v > hi) return lim;
    if (v < lo) return -lim;
    return v[INT_W-1:0];
  endfunction

endpackage

>>> sv/qapm_mul.sv
`timescale 1ns / 1ps

module qapm_mul (
  input  logic                              clk,
  input  logic signed [qapm_pkg::VAL_W-1:0] val,
  input  logic        [qapm_pkg::GAIN_W-1:0] gain,
  output logic signed [qapm_pkg::RND_W-1:0] rnd_r
);
  import qapm_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rsum;
  logic signed [PROD_W-1:0] rsh;

  // gain msb is always zero, so the signed view is its true value
  assign prod = PROD_W'(val) * PROD_W'($signed(gain));

  // round to nearest, ties up: add half an lsb then floor
  assign rsum = prod_r + (PROD_W'(1) <<< (GAIN_BITS - 1));
  assign rsh  = rsum >>> GAIN_BITS;

  always_ff @(posedge clk) begin
    prod_r <= prod;
    rnd_r  <= rsh[RND_W-1:0];
  end

endmodule

>>> sv/qapm_mix.sv
`timescale 1ns / 1ps

module qapm_mix (
  input  logic signed [qapm_pkg::MIX_W-1:0]   mix,
  input  logic        [qapm_pkg::PULSE_W-1:0] base,
  output logic        [qapm_pkg::PULSE_W-1:0] pulse
);
  import qapm_pkg::*;

  localparam logic signed [MIX_W:0] MAX_S = $signed({{(MIX_W+1-PULSE_W){1'b0}}, PULSE_MAX});
  localparam logic signed [MIX_W:0] MIN_S = $signed({{(MIX_W+1-PULSE_W){1'b0}}, PULSE_MIN});

  logic                  neg;
  logic [MIX_W-1:0]      mag;
  logic [MIX_W-1:0]      whole;
  logic signed [MIX_W:0] w;
  logic signed [MIX_W:0] sum;

  always_comb begin
    neg   = mix[MIX_W-1];
    mag   = neg ? MIX_W'(-mix) : MIX_W'(mix);
    // truncate toward zero on the magnitude
    whole = mag >> FRACTION_BITS;
    w     = neg ? -$signed({1'b0, whole}) : $signed({1'b0, whole});
    sum   = w + $signed({{(MIX_W+1-PULSE_W){1'b0}}, base});
    if (sum > MAX_S) begin
      pulse = PULSE_MAX;
    end else if (sum <= MIN_S) begin
      pulse = PULSE_MIN;
    end else begin
      pulse = sum[PULSE_W-1:0];
    end
  end

endmodule

>>> sv/quad_attitude_pid_mixer_top.sv
`timescale 1ns / 1ps
// An accepted request runs 13 multiplies on the one shared multiplier (states S_MUL,
// S_RND, S_ACC each), then the mixer in S_MIX and the output load in S_DONE.
// No new request is taken until the last is loaded; in_ready is high only while idle.
// A finished result waits in the output register while the next request is accepted.
// Reset (rst_n low, synchronous) clears integrals, last rates, sequencer and out_valid.
module quad_attitude_pid_mixer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_roll_angle,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_pitch_angle,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_rate_x,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_rate_y,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_rate_z,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_roll_target,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_pitch_target,
  input  logic signed [qapm_pkg::IN_W-1:0]    in_yaw_target,
  input  logic        [qapm_pkg::PULSE_W-1:0] in_base_throttle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [qapm_pkg::PULSE_W-1:0] out_motor_front_left,
  output logic        [qapm_pkg::PULSE_W-1:0] out_motor_front_right,
  output logic        [qapm_pkg::PULSE_W-1:0] out_motor_rear_right,
  output logic        [qapm_pkg::PULSE_W-1:0] out_motor_rear_left
);
  import qapm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_RND, S_ACC, S_MIX, S_DONE} state_t;

  state_t                    state_r;
  op_t                       op_r;
  logic [2:0]                cnt_r;

  logic signed [DIFF_W-1:0]  ex_r, ey_r, ez_r, dx_r, dy_r, dz_r;
  logic signed [IN_W-1:0]    gx_r, gy_r;
  logic signed [IN_W-1:0]    last_x_r, last_y_r, last_z_r;
  logic signed [VAL_W-1:0]   rx_r, ry_r;
  logic signed [INT_W-1:0]   ai_x_r, ri_x_r, ai_y_r, ri_y_r, yi_r;
  logic signed [ACC_W-1:0]   roll_r, pitch_r, yaw_r;
  logic [PULSE_W-1:0]        base_r;
  logic signed [MIX_W-1:0]   mix_r;
  logic [PULSE_W-1:0]        mot_r [4];
  logic                      out_valid_r;
  logic [PULSE_W-1:0]        fl_r, fr_r, rr_r, rl_r;

  logic signed [VAL_W-1:0]   val_sel;
  logic [GAIN_W-1:0]         gain_sel;
  logic signed [RND_W-1:0]   rnd_r;
  logic signed [INT_W-1:0]   int_cur;
  logic signed [INT_W-1:0]   int_lim;
  logic signed [INT_W-1:0]   int_new;
  logic signed [ACC_W-1:0]   acc_sel;
  logic signed [ACC_W-1:0]   acc_add;
  logic signed [ACC_W-1:0]   acc_new;
  logic signed [VAL_W-1:0]   rate_err;
  logic signed [MIX_W-1:0]   mix_sum;
  logic [PULSE_W-1:0]        pulse;
  logic [1:0]                mot_idx;

  qapm_mul u_mul (
    .clk   (clk),
    .val   (val_sel),
    .gain  (gain_sel),
    .rnd_r (rnd_r)
  );

  qapm_mix u_mix (
    .mix   (mix_r),
    .base  (base_r),
    .pulse (pulse)
  );

  // operand select for the shared multiplier
  always_comb begin
    gain_sel = gain_of(op_r);
    case (op_r)
      OP_ANG_P_X, OP_ANG_I_X:   val_sel = VAL_W'(ex_r);
      OP_RATE_I_X, OP_RATE_P_X: val_sel = rx_r;
      OP_RATE_D_X:              val_sel = VAL_W'(dx_r);
      OP_ANG_P_Y, OP_ANG_I_Y:   val_sel = VAL_W'(ey_r);
      OP_RATE_I_Y, OP_RATE_P_Y: val_sel = ry_r;
      OP_RATE_D_Y:              val_sel = VAL_W'(dy_r);
      OP_YAW_I, OP_YAW_P:       val_sel = VAL_W'(ez_r);
      OP_YAW_D:                 val_sel = VAL_W'(dz_r);
      default:                  val_sel = '0;
    endcase
  end

  // accumulate step
  always_comb begin
    case (op_r)
      OP_ANG_I_X:  begin int_cur = ai_x_r; int_lim = LIM_100; end
      OP_RATE_I_X: begin int_cur = ri_x_r; int_lim = LIM_150; end
      OP_ANG_I_Y:  begin int_cur = ai_y_r; int_lim = LIM_150; end
      OP_RATE_I_Y: begin int_cur = ri_y_r; int_lim = LIM_150; end
      OP_YAW_I:    begin int_cur = yi_r;   int_lim = LIM_100; end
      default:     begin int_cur = '0;     int_lim = LIM_100; end
    endcase
    int_new = clamp_int((INT_W+1)'(int_cur) + (INT_W+1)'(rnd_r), int_lim);

    case (op_r)
      OP_ANG_I_X, OP_RATE_I_X, OP_RATE_P_X, OP_RATE_D_X: acc_sel = roll_r;
      OP_ANG_I_Y, OP_RATE_I_Y, OP_RATE_P_Y, OP_RATE_D_Y: acc_sel = pitch_r;
      default:                                           acc_sel = yaw_r;
    endcase
    case (op_r)
      OP_ANG_I_X, OP_RATE_I_X, OP_ANG_I_Y, OP_RATE_I_Y, OP_YAW_I: acc_add = ACC_W'(int_new);
      OP_RATE_D_X, OP_RATE_D_Y, OP_YAW_D:                         acc_add = -rnd_r;
      default:                                                    acc_add = rnd_r;
    endcase
    acc_new  = acc_sel + acc_add;
    rate_err = VAL_W'(rnd_r) - VAL_W'((op_r == OP_ANG_P_X) ? gx_r : gy_r);
  end

  // X-frame mix, one motor per cycle
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    mix_sum =  MIX_W'(roll_r) - MIX_W'(pitch_r) + MIX_W'(yaw_r);
      2'd1:    mix_sum = -MIX_W'(roll_r) - MIX_W'(pitch_r) - MIX_W'(yaw_r);
      2'd2:    mix_sum = -MIX_W'(roll_r) + MIX_W'(pitch_r) + MIX_W'(yaw_r);
      default: mix_sum =  MIX_W'(roll_r) + MIX_W'(pitch_r) - MIX_W'(yaw_r);
    endcase
    mot_idx = cnt_r[1:0] - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_ANG_P_X;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      ai_x_r      <= '0;
      ri_x_r      <= '0;
      ai_y_r      <= '0;
      ri_y_r      <= '0;
      yi_r        <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
    end else begin
      // S_DONE sets out_valid_r itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ex_r     <= DIFF_W'(in_roll_target) - DIFF_W'(in_roll_angle);
            ey_r     <= DIFF_W'(in_pitch_target) - DIFF_W'(in_pitch_angle);
            ez_r     <= DIFF_W'(in_yaw_target) - DIFF_W'(in_rate_z);
            dx_r     <= DIFF_W'(in_rate_x) - DIFF_W'(last_x_r);
            dy_r     <= DIFF_W'(in_rate_y) - DIFF_W'(last_y_r);
            dz_r     <= DIFF_W'(in_rate_z) - DIFF_W'(last_z_r);
            gx_r     <= in_rate_x;
            gy_r     <= in_rate_y;
            last_x_r <= in_rate_x;
            last_y_r <= in_rate_y;
            last_z_r <= in_rate_z;
            base_r   <= in_base_throttle;
            roll_r   <= '0;
            pitch_r  <= '0;
            yaw_r    <= '0;
            op_r     <= OP_ANG_P_X;
            state_r  <= S_MUL;
          end
        end
        S_MUL: state_r <= S_RND;
        S_RND: state_r <= S_ACC;
        S_ACC: begin
          case (op_r)
            OP_ANG_P_X:  rx_r <= rate_err;
            OP_ANG_P_Y:  ry_r <= rate_err;
            OP_ANG_I_X:  begin ai_x_r <= int_new; roll_r  <= acc_new; end
            OP_RATE_I_X: begin ri_x_r <= int_new; roll_r  <= acc_new; end
            OP_ANG_I_Y:  begin ai_y_r <= int_new; pitch_r <= acc_new; end
            OP_RATE_I_Y: begin ri_y_r <= int_new; pitch_r <= acc_new; end
            OP_YAW_I:    begin yi_r   <= int_new; yaw_r   <= acc_new; end
            OP_RATE_P_X, OP_RATE_D_X: roll_r  <= acc_new;
            OP_RATE_P_Y, OP_RATE_D_Y: pitch_r <= acc_new;
            default:                  yaw_r   <= acc_new;
          endcase
          if (op_r == OP_YAW_D) begin
            cnt_r   <= '0;
            state_r <= S_MIX;
          end else begin
            op_r    <= op_t'(4'(op_r + 4'd1));
            state_r <= S_MUL;
          end
        end
        S_MIX: begin
          // mixer output is combinational on mix_r, so it trails mix_sum by the mix_r register
          mix_r <= mix_sum;
          if (cnt_r != 3'd0) begin
            mot_r[mot_idx] <= pulse;
          end
          if (cnt_r == 3'd4) begin
            state_r <= S_DONE;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            fl_r        <= mot_r[0];
            fr_r        <= mot_r[1];
            rr_r        <= mot_r[2];
            rl_r        <= mot_r[3];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready              = (state_r == S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_motor_front_left  = fl_r;
  assign out_motor_front_right = fr_r;
  assign out_motor_rear_right  = rr_r;
  assign out_motor_rear_left   = rl_r;

endmodule

>>> sv/qapm_chk.sv
`timescale 1ns / 1ps

module qapm_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [qapm_pkg::PULSE_W-1:0]      out_motor_front_left,
  input logic [qapm_pkg::PULSE_W-1:0]      out_motor_front_right,
  input logic [qapm_pkg::PULSE_W-1:0]      out_motor_rear_right,
  input logic [qapm_pkg::PULSE_W-1:0]      out_motor_rear_left
);
  import qapm_pkg::*;

  // one request in flight: ready drops right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor_front_left)
      && $stable(out_motor_front_right) && $stable(out_motor_rear_right)
      && $stable(out_motor_rear_left))
    else $error("stalled result changed");

  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_front_left >= PULSE_MIN && out_motor_front_left <= PULSE_MAX
      && out_motor_front_right >= PULSE_MIN && out_motor_front_right <= PULSE_MAX
      && out_motor_rear_right >= PULSE_MIN && out_motor_rear_right <= PULSE_MAX
      && out_motor_rear_left >= PULSE_MIN && out_motor_rear_left <= PULSE_MAX)
    else $error("motor pulse out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind quad_attitude_pid_mixer_top qapm_chk u_qapm_chk (.*);
